FILE: src/lpst_pkg.sv
// Types and constants for the LRU page slot table.
// Shared by lpst_cell and lru_page_slot_table; depends on nothing.
`default_nettype none

package lpst_pkg;

    localparam int PAGE_W     = 12;
    localparam int PCNT_W     = 13;
    localparam int SCNT_W     = 7;
    localparam int CFG_W      = 13;
    localparam int STAMP_W    = 64;
    // bound of the slot parameter range (1024 slots)
    localparam int SLOT_IDX_W = 10;
    localparam int LIM_W      = 11;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    localparam logic CFG_PAGE_LIM = 1'b0;
    localparam logic CFG_SLOT_LIM = 1'b1;

    // token that walks the cell row
    typedef struct packed {
        logic                  valid;
        logic [PAGE_W-1:0]     page;
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_slot;
        logic                  empty_found;
        logic [SLOT_IDX_W-1:0] empty_slot;
        logic                  vict_found;
        logic [SLOT_IDX_W-1:0] vict_slot;
        logic [STAMP_W-1:0]    vict_stamp;
        logic [PAGE_W-1:0]     vict_page;
    } scan_t;

    // broadcast update to one cell
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  set_owner;
        logic [PAGE_W-1:0]     page;
        logic [STAMP_W-1:0]    stamp;
    } wr_t;

endpackage

`default_nettype wire

FILE: src/lpst_cell.sv
// One slot of the table: owner page, valid bit and use stamp.
// Folds its slot into the passing scan token; uses lpst_pkg.
`default_nettype none

module lpst_cell #(
    parameter int IDX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lpst_pkg::scan_t     tok_in,
    output lpst_pkg::scan_t          tok_out,
    input  wire lpst_pkg::wr_t       wr,
    input  wire logic [lpst_pkg::LIM_W-1:0] slot_lim
);
    import lpst_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] MY_SLOT = SLOT_IDX_W'(IDX);
    localparam logic [LIM_W-1:0]      MY_LIM  = LIM_W'(IDX);

    logic               owner_valid_reg;
    logic [PAGE_W-1:0]  owner_page_reg;
    logic [STAMP_W-1:0] stamp_reg;
    scan_t              tok_reg;
    scan_t              tok_next;
    logic               in_range;
    logic               sel;

    assign in_range = MY_LIM < slot_lim;
    assign sel      = wr.en && (wr.slot == MY_SLOT);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && owner_valid_reg && (owner_page_reg == tok_in.page))
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_slot = MY_SLOT;
        end
        if (!tok_in.empty_found && in_range && !owner_valid_reg)
        begin
            tok_next.empty_found = 1'b1;
            tok_next.empty_slot  = MY_SLOT;
        end
        if (in_range && (!tok_in.vict_found || (stamp_reg < tok_in.vict_stamp)))
        begin
            tok_next.vict_found = 1'b1;
            tok_next.vict_slot  = MY_SLOT;
            tok_next.vict_stamp = stamp_reg;
            tok_next.vict_page  = owner_page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= 1'b0;
            stamp_reg       <= '0;
            tok_reg         <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel)
            begin
                stamp_reg <= wr.stamp;
                if (wr.set_owner)
                begin
                    owner_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr.set_owner)
        begin
            owner_page_reg <= wr.page;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: src/lru_page_slot_table.sv
// LRU page slot table: an input word passes the head register, one register per slot
// cell for the scan, then the result and output registers. One word in flight; a new
// input word is taken only once the previous result has moved to the output register.
// A finished result waits in the output register while the next word scans.
// Reset empties all slots, clears stamps, tick and fill count; page limit 4096,
// slot limit 64. No clearing pass is needed.
`default_nettype none

module lru_page_slot_table #(
    parameter int MAX_SLOTS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [lpst_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        command,
    input  wire logic [lpst_pkg::PAGE_W-1:0] page_id,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lpst_pkg::PAGE_W-1:0]      page_echo,
    output logic                             status,
    output logic                             slot_valid,
    output logic [5:0]                       slot,
    output logic                             page_loaded,
    output logic                             evicted_valid,
    output logic [lpst_pkg::PAGE_W-1:0]      victim_page,
    output logic [6:0]                       resident_total
);
    import lpst_pkg::*;

    localparam int RES_W = $clog2(MAX_SLOTS + 1);

    typedef struct packed {
        logic [PAGE_W-1:0]     page;
        logic                  status;
        logic                  sv;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  nl;
        logic                  ev;
        logic [PAGE_W-1:0]     evp;
        logic [RES_W-1:0]      resident;
    } res_t;

    logic [PCNT_W-1:0]  pages_reg;
    logic [SCNT_W-1:0]  slots_reg;
    logic [STAMP_W-1:0] tick_reg;
    logic [RES_W-1:0]   resident_reg;
    logic               busy_reg;
    logic               cmd_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               ok_reg;
    scan_t              head_reg;
    scan_t              head_next;
    res_t               res_reg;
    logic               res_valid_reg;
    res_t               out_reg;
    logic               out_valid_reg;

    scan_t              chain [0:MAX_SLOTS];
    wr_t                wr;
    res_t               res_next;
    logic [LIM_W-1:0]   slot_lim;
    logic [LIM_W-1:0]   sc_ext;
    logic               in_take;
    logic               commit;
    logic               req_ok;
    logic               fill_empty;
    logic [STAMP_W-1:0] tick_inc;
    logic [SLOT_IDX_W-1:0] target;
    logic               out_load;
    scan_t              tk;

    assign sc_ext = LIM_W'(slots_reg);
    always_comb
    begin
        if (slots_reg == '0)
        begin
            slot_lim = LIM_W'(1);
        end
        else if (sc_ext > LIM_W'(MAX_SLOTS))
        begin
            slot_lim = LIM_W'(MAX_SLOTS);
        end
        else
        begin
            slot_lim = sc_ext;
        end
    end

    assign in_stall = busy_reg || res_valid_reg;
    assign in_take  = in_valid && !in_stall;

    assign chain[0] = head_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_cell
            lpst_cell #(.IDX(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (chain[g]),
                .tok_out  (chain[g+1]),
                .wr       (wr),
                .slot_lim (slot_lim)
            );
        end
    endgenerate

    assign tk         = chain[MAX_SLOTS];
    assign commit     = tk.valid;
    assign req_ok     = ok_reg && (cmd_reg == CMD_REQUEST);
    assign fill_empty = req_ok && !tk.hit && tk.empty_found;
    assign tick_inc   = tick_reg + STAMP_W'(1);
    assign target     = tk.hit ? tk.hit_slot : (tk.empty_found ? tk.empty_slot : tk.vict_slot);

    always_comb
    begin
        head_next       = '0;
        head_next.valid = in_take;
        head_next.page  = page_id;
    end

    always_comb
    begin
        wr.en        = commit && req_ok;
        wr.slot      = target;
        wr.set_owner = !tk.hit;
        wr.page      = page_reg;
        wr.stamp     = tick_inc;
    end

    always_comb
    begin
        res_next.page     = page_reg;
        res_next.status   = !ok_reg;
        res_next.sv       = ok_reg && (tk.hit || (cmd_reg == CMD_REQUEST));
        res_next.slot     = '0;
        if (res_next.sv)
        begin
            res_next.slot = (cmd_reg == CMD_REQUEST) ? target : tk.hit_slot;
        end
        res_next.nl       = req_ok && !tk.hit;
        res_next.ev       = req_ok && !tk.hit && !tk.empty_found;
        res_next.evp      = res_next.ev ? tk.vict_page : '0;
        res_next.resident = resident_reg + RES_W'(fill_empty);
    end

    assign out_load = res_valid_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg      <= PCNT_W'(4096);
            slots_reg      <= SCNT_W'(64);
            tick_reg       <= '0;
            resident_reg   <= '0;
            busy_reg       <= 1'b0;
            head_reg       <= '0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PAGE_LIM: pages_reg <= cfg_data;
                    CFG_SLOT_LIM: slots_reg <= cfg_data[SCNT_W-1:0];
                    default: ;
                endcase
            end

            head_reg <= head_next;

            if (in_take)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end

            if (commit && req_ok)
            begin
                tick_reg <= tick_inc;
            end
            if (commit && fill_empty)
            begin
                resident_reg <= resident_reg + RES_W'(1);
            end

            if (commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                res_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= command;
            page_reg <= page_id;
            ok_reg   <= {1'b0, page_id} < pages_reg;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign page_echo      = out_reg.page;
    assign status         = out_reg.status;
    assign slot_valid     = out_reg.sv;
    assign slot           = out_reg.slot[5:0];
    assign page_loaded    = out_reg.nl;
    assign evicted_valid  = out_reg.ev;
    assign victim_page    = out_reg.evp;
    assign resident_total = 7'(out_reg.resident);

endmodule

`default_nettype wire
